[rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the Bresenham line pixel stepper
// Coordinate widths, payload structs of both channels, the per-line state
// record and the codes of the item kind and the configuration registers.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Coordinate width; the delta, error and compare widths below follow from it
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FB_BITS    = 15;
  localparam int unsigned COLOR_BITS = 32;

  // Major delta is a difference of two coordinates, twice minor delta one bit
  // more, and the error spans roughly minus one to plus three major deltas
  localparam int unsigned DELTA_BITS = COORD_BITS + 1;
  localparam int unsigned TWICE_BITS = COORD_BITS + 2;
  localparam int unsigned ERR_BITS   = COORD_BITS + 4;

  // Common width for the framebuffer bound compare
  localparam int unsigned CMP_BITS = (COORD_BITS > FB_BITS) ? COORD_BITS : FB_BITS;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = FB_BITS;

  localparam logic [FB_BITS-1:0] FB_WIDTH_RST  = FB_BITS'(640);
  localparam logic [FB_BITS-1:0] FB_HEIGHT_RST = FB_BITS'(480);

  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FB_WIDTH  = 1'b0,
    CFG_FB_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Input beat
  typedef struct packed {
    kind_e                 kind;
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [COLOR_BITS-1:0] line_color;
  } line_in_t;

  // Output beat
  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  write_enable;
    logic                  last;
  } pixel_out_t;

  // State of the line being drawn
  typedef struct packed {
    coord_t                       major_pos;
    coord_t                       minor_pos;
    coord_t                       major_end;
    logic signed [DELTA_BITS-1:0] major_delta;
    logic [TWICE_BITS-1:0]        twice_minor_delta;
    logic signed [ERR_BITS-1:0]   error_acc;
    logic                         minor_dir_down;
    logic                         axes_swapped;
    logic [COLOR_BITS-1:0]        held_color;
    logic                         drawing;
  } line_state_t;

endpackage

[rtl/bresenham_line_pixel_stepper.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_stepper: integer line pixel generator
// Holds the active line, steps it one pixel per step beat and registers the
// resulting point for the downstream pixel sink.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): a load beat
//   (kind = KIND_LOAD) sets up a new line from two endpoints and a colour and
//   replaces any line in progress; it yields no output beat. A step beat
//   (kind = KIND_STEP) yields the next point of the active line, or nothing
//   when no line is active. The last point carries last = 1 and ends the line.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one point a beat,
//   with write_enable set when it lies inside the framebuffer.
//   Configuration: cfg_we_i writes fb_width (index 0) or fb_height (index 1);
//   write only while the block is idle.
//   A step beat's point is registered for the next cycle; a beat is taken
//   every cycle unless the receiver stalls, as the step is a single add,
//   compare and increment on the line state before the output register.
//   When the receiver stalls, the point waits in the output register and the
//   input channel holds off until it is taken.
//   Reset clears the line state (no line active) and restores a 640 by 480
//   framebuffer.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_stepper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bls_pkg::line_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bls_pkg::pixel_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bls_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [bls_pkg::FB_BITS-1:0] fb_width_q, fb_height_q;
  bls_pkg::line_state_t        state_q, state_d;
  bls_pkg::line_state_t        setup_state, step_state;
  bls_pkg::pixel_out_t         step_pixel;
  bls_pkg::pixel_out_t         out_data_q;
  logic                        out_valid_q, out_valid_d;
  logic                        in_accept, is_load, emit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q  <= bls_pkg::FB_WIDTH_RST;
      fb_height_q <= bls_pkg::FB_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (bls_pkg::cfg_idx_e'(cfg_idx_i))
        bls_pkg::CFG_FB_WIDTH:  fb_width_q  <= cfg_data_i;
        bls_pkg::CFG_FB_HEIGHT: fb_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bls_line_setup u_setup (
    .load_i  (in_data_i),
    .setup_o (setup_state)
  );

  bls_pixel_step u_step (
    .cur_i       (state_q),
    .fb_width_i  (fb_width_q),
    .fb_height_i (fb_height_q),
    .pixel_o     (step_pixel),
    .next_o      (step_state)
  );

  // Take a beat whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_load    = (in_data_i.kind == bls_pkg::KIND_LOAD);
  assign emit       = in_accept && !is_load && state_q.drawing;

  // Next line state
  always_comb begin
    state_d = state_q;
    if (in_accept && is_load) begin
      state_d = setup_state;
    end else if (emit) begin
      state_d = step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= step_pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // A step with no active line yields no point
  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_load && !state_q.drawing |=> !out_valid_o)
    else $error("point emitted for a step with no active line");

  // The final point ends the line
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && step_pixel.last |=> !state_q.drawing)
    else $error("line still active after its final point");

  // A load starts a line with a cleared error
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_load |=> state_q.drawing && (state_q.error_acc == '0))
    else $error("load did not start a fresh line");

  // The error stays within one major delta either side of zero
  a_error_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.drawing |->
      (state_q.error_acc <= bls_pkg::ERR_BITS'(state_q.major_delta)) &&
      (state_q.error_acc >= -bls_pkg::ERR_BITS'(state_q.major_delta)))
    else $error("error accumulator out of range");

  // The major coordinate never passes the line end
  a_major_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.drawing |-> state_q.major_pos <= state_q.major_end)
    else $error("major coordinate beyond line end");
`endif

endmodule

[rtl/bls_line_setup.sv]
// ----------------------------------------------------------------------------
// bls_line_setup: line set-up from a load beat
// Picks the major axis, orders the endpoints so the major coordinate rises and
// derives the deltas, the minor direction and a cleared error.
// ----------------------------------------------------------------------------
module bls_line_setup (
  input  bls_pkg::line_in_t    load_i,
  output bls_pkg::line_state_t setup_o
);

  logic signed [bls_pkg::DELTA_BITS-1:0] dx, dy;
  logic [bls_pkg::DELTA_BITS-1:0]        adx, ady;
  logic                                  steep;
  bls_pkg::coord_t                       a0, b0, a1, b1;
  bls_pkg::coord_t                       lo_a, lo_b, hi_a, hi_b;
  logic signed [bls_pkg::DELTA_BITS-1:0] d_major, d_minor;
  logic [bls_pkg::DELTA_BITS-1:0]        ad_minor;

  // Measure both axes and decide whether the line is steep
  assign dx    = bls_pkg::DELTA_BITS'(load_i.end_x) - bls_pkg::DELTA_BITS'(load_i.start_x);
  assign dy    = bls_pkg::DELTA_BITS'(load_i.end_y) - bls_pkg::DELTA_BITS'(load_i.start_y);
  assign adx   = dx[bls_pkg::DELTA_BITS-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ady   = dy[bls_pkg::DELTA_BITS-1] ? $unsigned(-dy) : $unsigned(dy);
  assign steep = adx < ady;

  // Swap axes for a steep line
  assign a0 = steep ? load_i.start_y : load_i.start_x;
  assign b0 = steep ? load_i.start_x : load_i.start_y;
  assign a1 = steep ? load_i.end_y   : load_i.end_x;
  assign b1 = steep ? load_i.end_x   : load_i.end_y;

  // Order the endpoints so the major coordinate rises
  always_comb begin
    if (a0 > a1) begin
      lo_a = a1;
      lo_b = b1;
      hi_a = a0;
      hi_b = b0;
    end else begin
      lo_a = a0;
      lo_b = b0;
      hi_a = a1;
      hi_b = b1;
    end
  end

  assign d_major  = bls_pkg::DELTA_BITS'(hi_a) - bls_pkg::DELTA_BITS'(lo_a);
  assign d_minor  = bls_pkg::DELTA_BITS'(hi_b) - bls_pkg::DELTA_BITS'(lo_b);
  assign ad_minor = d_minor[bls_pkg::DELTA_BITS-1] ? $unsigned(-d_minor) : $unsigned(d_minor);

  // Assemble the fresh line state
  always_comb begin
    setup_o                   = '0;
    setup_o.major_pos         = lo_a;
    setup_o.minor_pos         = lo_b;
    setup_o.major_end         = hi_a;
    setup_o.major_delta       = d_major;
    setup_o.twice_minor_delta = {ad_minor, 1'b0};
    setup_o.error_acc         = '0;
    setup_o.minor_dir_down    = !(hi_b > lo_b);
    setup_o.axes_swapped      = steep;
    setup_o.held_color        = load_i.line_color;
    setup_o.drawing           = 1'b1;
  end

endmodule

[rtl/bls_pixel_step.sv]
// ----------------------------------------------------------------------------
// bls_pixel_step: one Bresenham step
// Forms the current point with its write and last flags, and the line state
// after the point: error update, minor move and major increment.
// ----------------------------------------------------------------------------
module bls_pixel_step (
  input  bls_pkg::line_state_t         cur_i,
  input  logic [bls_pkg::FB_BITS-1:0]  fb_width_i,
  input  logic [bls_pkg::FB_BITS-1:0]  fb_height_i,
  output bls_pkg::pixel_out_t          pixel_o,
  output bls_pkg::line_state_t         next_o
);

  bls_pkg::coord_t                     px, py;
  logic [bls_pkg::CMP_BITS-1:0]        px_u, py_u, w_u, h_u;
  logic                                in_frame;
  logic                                fin;
  logic signed [bls_pkg::ERR_BITS-1:0] twice_e, md_e, err_add;

  // Map major and minor back to x and y
  assign px = cur_i.axes_swapped ? cur_i.minor_pos : cur_i.major_pos;
  assign py = cur_i.axes_swapped ? cur_i.major_pos : cur_i.minor_pos;

  // Framebuffer bound check; a negative coordinate is always outside
  assign px_u     = bls_pkg::CMP_BITS'($unsigned(px));
  assign py_u     = bls_pkg::CMP_BITS'($unsigned(py));
  assign w_u      = bls_pkg::CMP_BITS'(fb_width_i);
  assign h_u      = bls_pkg::CMP_BITS'(fb_height_i);
  assign in_frame = !px[bls_pkg::COORD_BITS-1] && (px_u < w_u) &&
                    !py[bls_pkg::COORD_BITS-1] && (py_u < h_u);

  assign fin = cur_i.major_pos >= cur_i.major_end;

  always_comb begin
    pixel_o.pixel_x      = px;
    pixel_o.pixel_y      = py;
    pixel_o.pixel_color  = cur_i.held_color;
    pixel_o.write_enable = in_frame;
    pixel_o.last         = fin;
  end

  // Accumulate the error
  assign twice_e = bls_pkg::ERR_BITS'($signed({1'b0, cur_i.twice_minor_delta}));
  assign md_e    = bls_pkg::ERR_BITS'(cur_i.major_delta);
  assign err_add = cur_i.error_acc + twice_e;

  // Advance along the line, or drop the line after its final point
  always_comb begin
    next_o = cur_i;
    if (fin) begin
      next_o.drawing = 1'b0;
    end else begin
      next_o.major_pos = cur_i.major_pos + bls_pkg::coord_t'(1);
      next_o.error_acc = err_add;
      if (err_add >= md_e) begin
        next_o.minor_pos = cur_i.minor_dir_down ? cur_i.minor_pos - bls_pkg::coord_t'(1)
                                                : cur_i.minor_pos + bls_pkg::coord_t'(1);
        next_o.error_acc = err_add - (md_e <<< 1);
      end
    end
  end

endmodule

[verif/bls_pixel_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bls_pixel_checker: scoreboard for the Bresenham line pixel stepper
// Watches the configuration port and both beat channels, keeps its own copy of
// the framebuffer size and the active line, predicts the point of every
// accepted step beat and compares each point leaving the block, field by
// field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module bls_pixel_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  bls_pkg::line_in_t                 in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  bls_pkg::pixel_out_t               out_data_i,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bls_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  // Framebuffer size as last written
  logic [bls_pkg::FB_BITS-1:0] fb_width_q;
  logic [bls_pkg::FB_BITS-1:0] fb_height_q;

  // Line being drawn
  bls_pkg::coord_t                       major_pos;
  bls_pkg::coord_t                       minor_pos;
  bls_pkg::coord_t                       major_end;
  logic signed [bls_pkg::DELTA_BITS-1:0] major_delta;
  logic [bls_pkg::TWICE_BITS-1:0]        twice_minor_delta;
  logic signed [bls_pkg::ERR_BITS-1:0]   error_acc;
  logic                                  minor_down;
  logic                                  axes_swapped;
  logic                                  drawing;
  logic [bls_pkg::COLOR_BITS-1:0]        held_color;

  // Points predicted but not yet seen on the output channel
  bls_pkg::pixel_out_t predicted_points[$];
  bls_pkg::pixel_out_t oldest_point;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    fail_count_o++;
    $display("[%0t] pixel check: %s", $time, msg);
  endtask

  // Latch a new line: swap steep lines, order the ends so the major axis rises
  task automatic latch_line(bls_pkg::line_in_t beat);
    longint a0, b0, a1, b1, t;
    bit     steep;
    a0 = beat.start_x;
    b0 = beat.start_y;
    a1 = beat.end_x;
    b1 = beat.end_y;
    steep = magnitude(a1 - a0) < magnitude(b1 - b0);
    if (steep) begin
      t = a0; a0 = b0; b0 = t;
      t = a1; a1 = b1; b1 = t;
    end
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    major_pos         = bls_pkg::coord_t'(a0);
    minor_pos         = bls_pkg::coord_t'(b0);
    major_end         = bls_pkg::coord_t'(a1);
    major_delta       = a1 - a0;
    twice_minor_delta = magnitude(b1 - b0) * 2;
    error_acc         = '0;
    minor_down        = !(b1 > b0);
    axes_swapped      = steep;
    held_color        = beat.line_color;
    drawing           = 1'b1;
  endtask

  // Emit the current point, then advance along the line
  task automatic predict_point();
    bls_pkg::pixel_out_t p;
    longint              err;
    p.pixel_x      = axes_swapped ? minor_pos : major_pos;
    p.pixel_y      = axes_swapped ? major_pos : minor_pos;
    p.pixel_color  = held_color;
    p.write_enable = (p.pixel_x >= 0) && (longint'(p.pixel_x) < longint'(fb_width_q)) &&
                     (p.pixel_y >= 0) && (longint'(p.pixel_y) < longint'(fb_height_q));
    p.last         = (major_pos >= major_end);
    predicted_points.push_back(p);
    if (p.last) begin
      drawing = 1'b0;
    end else begin
      err = longint'(error_acc) + longint'(twice_minor_delta);
      if (err >= longint'(major_delta)) begin
        minor_pos = minor_down ? minor_pos - 1 : minor_pos + 1;
        err       = err - 2 * longint'(major_delta);
      end
      error_acc = err;
      major_pos = major_pos + 1;
    end
  endtask

  // Compare one output beat with the oldest prediction
  task automatic compare_point(bls_pkg::pixel_out_t got);
    if (predicted_points.size() == 0) begin
      report_mismatch($sformatf("point (%0d,%0d) with none predicted",
                                got.pixel_x, got.pixel_y));
    end else begin
      oldest_point = predicted_points.pop_front();
      if (got.pixel_x !== oldest_point.pixel_x)
        report_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, oldest_point.pixel_x));
      if (got.pixel_y !== oldest_point.pixel_y)
        report_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, oldest_point.pixel_y));
      if (got.pixel_color !== oldest_point.pixel_color)
        report_mismatch($sformatf("pixel_color %h, want %h",
                                  got.pixel_color, oldest_point.pixel_color));
      if (got.write_enable !== oldest_point.write_enable)
        report_mismatch($sformatf("write_enable %b, want %b at (%0d,%0d)", got.write_enable,
                                  oldest_point.write_enable, oldest_point.pixel_x,
                                  oldest_point.pixel_y));
      if (got.last !== oldest_point.last)
        report_mismatch($sformatf("last %b, want %b at (%0d,%0d)", got.last,
                                  oldest_point.last, oldest_point.pixel_x,
                                  oldest_point.pixel_y));
    end
  endtask

  // Follow register writes, then input beats, then output beats of each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q        = bls_pkg::FB_WIDTH_RST;
      fb_height_q       = bls_pkg::FB_HEIGHT_RST;
      major_pos         = '0;
      minor_pos         = '0;
      major_end         = '0;
      major_delta       = '0;
      twice_minor_delta = '0;
      error_acc         = '0;
      minor_down        = 1'b0;
      axes_swapped      = 1'b0;
      drawing           = 1'b0;
      held_color        = '0;
      predicted_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (bls_pkg::cfg_idx_e'(cfg_idx_i))
          bls_pkg::CFG_FB_WIDTH:  fb_width_q  = cfg_data_i;
          bls_pkg::CFG_FB_HEIGHT: fb_height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == bls_pkg::KIND_LOAD) latch_line(in_data_i);
        else if (drawing) predict_point();
      end
      if (out_valid_i && out_ready_i) compare_point(out_data_i);
    end
    pending_o = predicted_points.size();
  end

endmodule

[verif/tb_bresenham_line_pixel_stepper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_pixel_stepper: testbench of the line pixel stepper
// Drives load and step beats, framebuffer size writes and random idling on
// both channels; a checker beside the block predicts and compares every
// point. A directed opening covers single-point, steep, reversed, diagonal
// and range-edge lines; random lines near the framebuffer edges follow under
// a series of framebuffer sizes, zero and full size among them.
// ----------------------------------------------------------------------------
module tb_bresenham_line_pixel_stepper;

  logic                              clk;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  bls_pkg::line_in_t                 in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  bls_pkg::pixel_out_t               out_data;
  logic                              cfg_we    = 1'b0;
  logic [bls_pkg::CFG_IDX_BITS-1:0]  cfg_idx   = bls_pkg::CFG_FB_WIDTH;
  logic [bls_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus state
  int  fb_w         = 640;
  int  fb_h         = 480;
  int  useful_items = 0;
  bit  calm         = 1'b0;
  logic hold_req    = 1'b0;

  bresenham_line_pixel_stepper i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  bls_pixel_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Pixel sink: random stalls, plus one long hold-off on each toggle of hold_req
  initial begin : pixel_sink
    logic hold_seen;
    hold_seen = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // Offer one beat, after occasional random idling, and hold it until taken
  task automatic send_beat(bls_pkg::line_in_t beat);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_line(longint x0, longint y0, longint x1, longint y1,
                           logic [bls_pkg::COLOR_BITS-1:0] color);
    bls_pkg::line_in_t beat;
    beat.kind       = bls_pkg::KIND_LOAD;
    beat.start_x    = bls_pkg::coord_t'(x0);
    beat.start_y    = bls_pkg::coord_t'(y0);
    beat.end_x      = bls_pkg::coord_t'(x1);
    beat.end_y      = bls_pkg::coord_t'(y1);
    beat.line_color = color;
    useful_items++;
    send_beat(beat);
  endtask

  // Step beats carry junk in the fields the block ignores
  task automatic send_steps(longint n, bit counted);
    bls_pkg::line_in_t beat;
    repeat (n) begin
      beat.kind       = bls_pkg::KIND_STEP;
      beat.start_x    = bls_pkg::coord_t'($urandom);
      beat.start_y    = bls_pkg::coord_t'($urandom);
      beat.end_x      = bls_pkg::coord_t'($urandom);
      beat.end_y      = bls_pkg::coord_t'($urandom);
      beat.line_color = $urandom;
      if (counted) useful_items++;
      send_beat(beat);
    end
  endtask

  // Stop offering and wait until every predicted point has left the block
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the width register, then the height register; call only when idle
  task automatic configure_fb(int w, int h);
    cfg_we   <= 1'b1;
    cfg_idx  <= bls_pkg::CFG_FB_WIDTH;
    cfg_data <= bls_pkg::CFG_DATA_BITS'(w);
    @(posedge clk);
    cfg_idx  <= bls_pkg::CFG_FB_HEIGHT;
    cfg_data <= bls_pkg::CFG_DATA_BITS'(h);
    @(posedge clk);
    cfg_we   <= 1'b0;
    fb_w = w;
    fb_h = h;
  endtask

  function automatic longint clamp_coord(longint v);
    longint lim;
    lim = longint'(1) <<< (bls_pkg::COORD_BITS - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Pick a coordinate near the origin, near the framebuffer edge or anywhere
  function automatic longint near_edge(int edge_px);
    case ($urandom_range(3))
      0:       return longint'($urandom_range(16)) - 8;
      1:       return longint'(edge_px) + longint'($urandom_range(16)) - 8;
      2:       return longint'($urandom_range(edge_px));
      default: return longint'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // One line: mostly short lines walked to the end, some cut short by the next
  // load, some with steps past the end, some with arbitrary endpoints
  task automatic random_line();
    longint      x0, y0, x1, y1, span, dx, dy, len;
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 10) begin
      x0 = bls_pkg::coord_t'($urandom);
      y0 = bls_pkg::coord_t'($urandom);
      x1 = bls_pkg::coord_t'($urandom);
      y1 = bls_pkg::coord_t'($urandom);
    end else begin
      span = ($urandom_range(19) == 0) ? 200 : 12;
      x0 = clamp_coord(near_edge(fb_w));
      y0 = clamp_coord(near_edge(fb_h));
      x1 = clamp_coord(x0 + longint'($urandom_range(2 * span)) - span);
      y1 = clamp_coord(y0 + longint'($urandom_range(2 * span)) - span);
    end
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    len = ((dx > dy) ? dx : dy) + 1;
    load_line(x0, y0, x1, y1, $urandom);
    if (mode < 10) begin
      send_steps((len < 6) ? len : $urandom_range(6, 1), 1'b1);
    end else if (mode < 22) begin
      send_steps($urandom_range(len - 1), 1'b1);
    end else begin
      send_steps(len, 1'b1);
      if (mode >= 92) send_steps($urandom_range(2, 1), 1'b0);
    end
  endtask

  initial begin : stimulus
    int w, h, stop;
    bit paused;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Step with no line loaded yet: dropped
    send_steps(1, 1'b0);
    // Single-point line, then a step past its end
    load_line(5, 5, 5, 5, 32'hFFFF_FFFF);
    send_steps(1, 1'b1);
    send_steps(1, 1'b0);
    // Shallow rising line from the origin
    load_line(0, 0, 2, 1, 32'h0000_0000);
    send_steps(3, 1'b1);
    // Reversed ends across the framebuffer corner
    load_line(640, 480, 638, 479, 32'h00FF_00FF);
    send_steps(3, 1'b1);
    // Steep line with the minor axis falling
    load_line(10, 2, 9, 5, $urandom);
    send_steps(4, 1'b1);
    // Equal deltas, reaching below and left of the framebuffer
    load_line(1, 1, -1, -1, $urandom);
    send_steps(3, 1'b1);
    // Full coordinate range: walk the first points, then replace the line
    load_line(-32768, 32767, 32767, -32768, $urandom);
    send_steps(2, 1'b1);
    // Top end of the coordinate range
    load_line(32766, 32767, 32767, 32767, $urandom);
    send_steps(2, 1'b1);

    // Random lines under a series of framebuffer sizes
    paused = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin w = 1;     h = 1;     end
        1:       begin w = 32767; h = 32767; end
        2:       begin w = 0;     h = 32767; end
        3:       begin w = 32767; h = 0;     end
        4:       begin w = 640;   h = 480;   end
        default: begin w = $urandom_range(32767, 1); h = $urandom_range(32767, 1); end
      endcase
      drain_outputs();
      configure_fb(w, h);
      calm = (ph == 2);
      // Long sink hold-off while lines keep coming
      if (ph == 1) hold_req <= ~hold_req;
      stop = useful_items + 285;
      while (useful_items < stop) begin
        random_line();
        if (ph == 3 && !paused && useful_items >= stop - 140) begin
          drain_outputs();
          paused = 1'b1;
        end
      end
    end

    drain_outputs();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
